### rtl/button_debounce_short_long_press_defines.svh
// Assertion macros for the button debounce block.
`ifndef BUTTON_DEBOUNCE_SHORT_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_SHORT_LONG_PRESS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BDSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bdsl_pkg.sv
// Package for the button debounce block: codes, widths and constants.
package bdsl_pkg;

  localparam int unsigned US_PER_MS   = 1000;
  localparam int unsigned DEB_MS_W    = 10;
  localparam int unsigned LONG_MS_W   = 16;
  localparam int unsigned DEB_US_W    = 20;  // 1023 * 1000 < 2**20
  localparam int unsigned LONG_US_W   = 26;  // 65535 * 1000 < 2**26
  localparam int unsigned TS_W        = 32;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned DEB_MS_RST  = 20;
  localparam int unsigned LONG_MS_RST = 3000;

  typedef enum logic {
    CMD_POLL = 1'b0,
    CMD_EDGE = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_DEBOUNCE_MS = 1'b0,
    REG_LONG_MS     = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_ev_t;

endpackage

### rtl/button_debounce_short_long_press.sv
// Button debounce with short and long press detection, single stage.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  in_     | in  | in_tvalid/tready   | tuser: cmd; tdata: now_us, level, edges
//  out_    | out | out_tvalid/tready  | tdata: press_event, is_pressed
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
//  One item per cycle sustained while out_tready is high. An accepted transfer
//  lands in the input register; the state-update pass then computes the result
//  and updates state in one pass, loading the result register behind out_tvalid.
//  Throughput is set by the single state-update stage (subtract and compare on
//  32-bit timestamps against registered microsecond thresholds).
//  Output stall holds the result register; the input register still takes a
//  transfer in the same cycle the result is taken.
//  Reset (rst_n low, sync) clears valid and button state, restores 20 ms / 3000 ms.
//  cfg_ready is always high; thresholds are scaled to microseconds on write.
`include "button_debounce_short_long_press_defines.svh"

module button_debounce_short_long_press
  import bdsl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    in_tvalid,
  output logic                    in_tready,
  // [31:0] now_us, [32] level, [33] rise_edge, [34] fall_edge, [39:35] zero
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  // [0] cmd
  input  logic                    in_tuser,

  output logic                    out_tvalid,
  input  logic                    out_tready,
  // [1:0] press_event, [2] is_pressed, [7:3] zero
  output logic [OUT_TDATA_W-1:0]  out_tdata,

  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  // Thresholds in microseconds
  logic [DEB_US_W-1:0]  deb_us_r;
  logic [LONG_US_W-1:0] long_us_r;

  // Input register
  logic                 in_valid_r;
  logic                 cmd_r;
  logic [TS_W-1:0]      now_r;
  logic                 level_r;
  logic                 rise_r;
  logic                 fall_r;

  // Result register
  logic                 out_valid_r;
  press_ev_t            ev_r;
  logic                 is_pressed_r;

  // Button state
  logic            edge_seen_r,  edge_seen_nxt;
  logic [TS_W-1:0] last_edge_r,  last_edge_nxt;
  logic            rise_seen_r,  rise_seen_nxt;
  logic [TS_W-1:0] rise_time_r,  rise_time_nxt;
  logic            fall_seen_r,  fall_seen_nxt;
  logic [TS_W-1:0] fall_time_r,  fall_time_nxt;
  logic            last_level_r, last_level_nxt;
  logic [TS_W-1:0] lvl_time_r,   lvl_time_nxt;
  logic            pressed_r,    pressed_nxt;
  logic            long_done_r,  long_done_nxt;
  logic [TS_W-1:0] press_start_r, press_start_nxt;
  press_ev_t       ev_nxt;

  logic            adv;
  logic            cfg_wr;
  logic [TS_W-1:0] deb_ext;
  logic [TS_W-1:0] long_ext;
  logic [TS_W-1:0] lvl_age;
  logic [TS_W-1:0] edge_age;
  logic [TS_W-1:0] hold_age;
  logic [TS_W-1:0] span;
  logic            settled;
  logic            rise_seen_e;

  // Stage advances when the result register is free or being drained.
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, is_pressed_r, ev_r};

  // Threshold registers, scaled to microseconds as they are written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_us_r  <= DEB_US_W'(DEB_MS_RST * US_PER_MS);
      long_us_r <= LONG_US_W'(LONG_MS_RST * US_PER_MS);
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE_MS: deb_us_r  <= DEB_US_W'(cfg_data[DEB_MS_W-1:0]) *
                                      DEB_US_W'(US_PER_MS);
        REG_LONG_MS:     long_us_r <= LONG_US_W'(cfg_data[LONG_MS_W-1:0]) *
                                      LONG_US_W'(US_PER_MS);
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r   <= in_tuser;
      now_r   <= in_tdata[TS_W-1:0];
      level_r <= in_tdata[TS_W];
      rise_r  <= in_tdata[TS_W+1];
      fall_r  <= in_tdata[TS_W+2];
    end
  end

  // Time differences wrap modulo 2**32.
  assign deb_ext  = TS_W'(deb_us_r);
  assign long_ext = TS_W'(long_us_r);
  // A level change in this poll restarts the settle window at zero age.
  assign lvl_age  = (level_r != last_level_r) ? '0 : now_r - lvl_time_r;
  assign edge_age = now_r - last_edge_r;
  assign hold_age = now_r - press_start_r;
  assign span     = fall_time_r - rise_time_r;
  assign settled  = (lvl_age >= deb_ext) && (!edge_seen_r || edge_age >= deb_ext);
  assign rise_seen_e = rise_seen_r || rise_r;

  always_comb begin
    edge_seen_nxt   = edge_seen_r;
    last_edge_nxt   = last_edge_r;
    rise_seen_nxt   = rise_seen_r;
    rise_time_nxt   = rise_time_r;
    fall_seen_nxt   = fall_seen_r;
    fall_time_nxt   = fall_time_r;
    last_level_nxt  = last_level_r;
    lvl_time_nxt    = lvl_time_r;
    pressed_nxt     = pressed_r;
    long_done_nxt   = long_done_r;
    press_start_nxt = press_start_r;
    ev_nxt          = EV_NONE;

    unique case (cmd_t'(cmd_r))
      CMD_EDGE: begin
        if (rise_r || fall_r) begin
          edge_seen_nxt = 1'b1;
          last_edge_nxt = now_r;
          if (rise_r && !rise_seen_r) begin
            rise_seen_nxt = 1'b1;
            rise_time_nxt = now_r;
          end
          // a fall before any rise is dropped
          if (fall_r && rise_seen_e) begin
            fall_seen_nxt = 1'b1;
            fall_time_nxt = now_r;
          end
        end
      end
      CMD_POLL: begin
        if (level_r != last_level_r) begin
          last_level_nxt = level_r;
          lvl_time_nxt   = now_r;
        end
        if (!pressed_r) begin
          if (settled) begin
            // history is cleared on every settled idle poll
            rise_seen_nxt = 1'b0;
            fall_seen_nxt = 1'b0;
            if (level_r) begin
              pressed_nxt     = 1'b1;
              long_done_nxt   = 1'b0;
              press_start_nxt = rise_seen_r ? rise_time_r :
                                (level_r != last_level_r) ? now_r : lvl_time_r;
            end else if (rise_seen_r && fall_seen_r && span >= deb_ext) begin
              ev_nxt = (span >= long_ext) ? EV_LONG : EV_SHORT;
            end
          end
        end else begin
          priority if (!long_done_r && hold_age >= long_ext) begin
            long_done_nxt = 1'b1;
            ev_nxt        = EV_LONG;
          end else if (!level_r && settled) begin
            pressed_nxt   = 1'b0;
            rise_seen_nxt = 1'b0;
            fall_seen_nxt = 1'b0;
            ev_nxt        = long_done_r ? EV_NONE : EV_SHORT;
          end else begin
            ev_nxt = EV_NONE;
          end
        end
      end
    endcase
  end

  // State and result update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_seen_r   <= 1'b0;
      last_edge_r   <= '0;
      rise_seen_r   <= 1'b0;
      rise_time_r   <= '0;
      fall_seen_r   <= 1'b0;
      fall_time_r   <= '0;
      last_level_r  <= 1'b0;
      lvl_time_r    <= '0;
      pressed_r     <= 1'b0;
      long_done_r   <= 1'b0;
      press_start_r <= '0;
    end else if (adv) begin
      edge_seen_r   <= edge_seen_nxt;
      last_edge_r   <= last_edge_nxt;
      rise_seen_r   <= rise_seen_nxt;
      rise_time_r   <= rise_time_nxt;
      fall_seen_r   <= fall_seen_nxt;
      fall_time_r   <= fall_time_nxt;
      last_level_r  <= last_level_nxt;
      lvl_time_r    <= lvl_time_nxt;
      pressed_r     <= pressed_nxt;
      long_done_r   <= long_done_nxt;
      press_start_r <= press_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ev_r         <= ev_nxt;
      is_pressed_r <= pressed_nxt;
    end
  end

  // Checks
  `BDSL_ASSERT_NOW(a_fall_needs_rise, fall_seen_r, rise_seen_r,
                   "fall recorded without a rise")
  `BDSL_ASSERT_NEXT(a_edge_no_event, adv && cmd_r == CMD_EDGE, ev_r == EV_NONE,
                    "edge report produced a press event")
  `BDSL_ASSERT_NOW(a_short_released, out_valid_r && ev_r == EV_SHORT, !is_pressed_r,
                   "short press reported while pressed")
  `BDSL_ASSERT_NEXT(a_stall_holds_item, in_valid_r && !adv, in_valid_r,
                    "input item lost during stall")

endmodule
